// ----- rtl/core/aff_pkg.sv -----
// ----------------------------------------------------------------------------
// aff_pkg: shared types and constants of the affine point transform
// Widths of the Q16.16 datapath, register indexes and reset values, and
// the stage-enable bundle that the pipeline control hands to the row units.
// ----------------------------------------------------------------------------
package aff_pkg;

  localparam int COORD_W   = 32;                     // Q16.16 coordinate
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COORD_W;            // full product
  localparam int SUM_W     = PROD_W + 2;             // three products plus offset
  localparam int QUOT_W    = SUM_W - FRAC_BITS;      // sum after the floor shift
  localparam int NUM_AXES  = 3;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

  // Reset values form the identity transform
  localparam logic [CFG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
  localparam logic [CFG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // Load enables of the three datapath stages
  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic out_en;
  } pipe_ctrl_t;

  // Occupancy of the three stages, stage 0 first
  typedef struct packed {
    logic [2:0] valid;
  } pipe_stat_t;

endpackage

// ----- rtl/core/aff_ctrl.sv -----
// ----------------------------------------------------------------------------
// aff_ctrl: valid tracking and stall control of the three-stage pipeline
// Each stage loads when it is empty or when the stage after it moves on,
// so bubbles collapse and a stall at the output loses nothing.
// ----------------------------------------------------------------------------
module aff_ctrl import aff_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output pipe_ctrl_t ctrl,
  output pipe_stat_t stat
);

  logic [2:0] valid;
  logic [2:0] load;

  always_comb begin
    load[2] = !valid[2] || out_ready;
    load[1] = !valid[1] || load[2];
    load[0] = !valid[0] || load[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) valid[0] <= in_valid;
      if (load[1]) valid[1] <= valid[0];
      if (load[2]) valid[2] <= valid[1];
    end
  end

  assign in_ready    = load[0];
  assign out_valid   = valid[2];
  assign ctrl.mul_en = load[0];
  assign ctrl.add_en = load[1];
  assign ctrl.out_en = load[2];
  assign stat.valid  = valid;

endmodule

// ----- rtl/core/aff_row.sv -----
// ----------------------------------------------------------------------------
// aff_row: datapath of one matrix row
// Multiply, pair-wise add with the shifted translation, then final add,
// floor shift and saturation into a Q16.16 coordinate.
// ----------------------------------------------------------------------------
module aff_row import aff_pkg::*; (
  input  logic                      clk,
  input  pipe_ctrl_t                ctrl,
  input  logic signed [COORD_W-1:0] m0,
  input  logic signed [COORD_W-1:0] m1,
  input  logic signed [COORD_W-1:0] m2,
  input  logic signed [COORD_W-1:0] t,
  input  logic signed [COORD_W-1:0] x,
  input  logic signed [COORD_W-1:0] y,
  input  logic signed [COORD_W-1:0] z,
  output logic signed [COORD_W-1:0] coord,
  output logic                      clamp
);

  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [SUM_W-1:0]  s01, s2t;
  logic signed [SUM_W-1:0]  t_ext;
  logic signed [SUM_W-1:0]  total;
  logic        [QUOT_W-1:0] quot;
  logic                     in_range;

  assign t_ext = SUM_W'(t) <<< FRAC_BITS;

  // Stage 0: full products
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p0 <= m0 * x;
      p1 <= m1 * y;
      p2 <= m2 * z;
    end
  end

  // Stage 1: two partial sums, exact
  always_ff @(posedge clk) begin
    if (ctrl.add_en) begin
      s01 <= SUM_W'(p0) + SUM_W'(p1);
      s2t <= SUM_W'(p2) + t_ext;
    end
  end

  // Stage 2: final sum, floor shift, clamp to 32 bits
  always_comb begin
    total    = s01 + s2t;
    quot     = total[SUM_W-1:FRAC_BITS];
    in_range = (&quot[QUOT_W-1:COORD_W-1]) || !(|quot[QUOT_W-1:COORD_W-1]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      clamp <= !in_range;
      if (in_range) begin
        coord <= quot[COORD_W-1:0];
      end else if (quot[QUOT_W-1]) begin
        coord <= COORD_MIN;
      end else begin
        coord <= COORD_MAX;
      end
    end
  end

endmodule

// ----- rtl/core/affine_point_transform_core.sv -----
// ----------------------------------------------------------------------------
// affine_point_transform_core: 3x4 affine transform of Q16.16 points
// Streams points in, applies the configured matrix and translation, and
// streams saturated points out with a clamp flag.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point per transaction: tdata = {z, y, x}, x lowest.
//   m_axis returns one transformed point per input: tdata = {z, y, x} and
//   tuser = clamped, set when any coordinate hit the 32-bit limits.
//   The cfg port writes one 64-bit matrix register per cycle (cfg_we high);
//   indexes beyond row2_cols23 are dropped. Write only while the pipe is
//   empty. Reset loads the identity matrix and empties the pipeline.
// Pipeline: an input transaction passes the multiply stage, the partial-sum
//   stage and the final-sum and saturate stage before its result is on m_axis.
// Throughput: one point per cycle while m_axis_tready is high; every row
//   has its own three 32x32 multipliers, so nothing is shared between points.
// Stall: when m_axis_tready is low the output stage holds; earlier stages
//   keep filling until every stage is full, then s_axis_tready drops. No
//   point is lost or repeated.
// ----------------------------------------------------------------------------
module affine_point_transform_core import aff_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [NUM_AXES*COORD_W-1:0]   s_axis_tdata,  // in_x, in_y, in_z
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [NUM_AXES*COORD_W-1:0]   m_axis_tdata,  // out_x, out_y, out_z
  output logic                          m_axis_tuser   // clamped
);

  logic [CFG_W-1:0] row0_cols01, row0_cols23;
  logic [CFG_W-1:0] row1_cols01, row1_cols23;
  logic [CFG_W-1:0] row2_cols01, row2_cols23;

  pipe_ctrl_t ctrl;
  pipe_stat_t stat;

  logic signed [COORD_W-1:0] in_x, in_y, in_z;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      clamp_x, clamp_y, clamp_z;

  // Matrix registers; unknown indexes fall through and change nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      row0_cols01 <= RST_ROW0_COLS01;
      row0_cols23 <= RST_ROW0_COLS23;
      row1_cols01 <= RST_ROW1_COLS01;
      row1_cols23 <= RST_ROW1_COLS23;
      row2_cols01 <= RST_ROW2_COLS01;
      row2_cols23 <= RST_ROW2_COLS23;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0_COLS01: row0_cols01 <= cfg_data;
        REG_ROW0_COLS23: row0_cols23 <= cfg_data;
        REG_ROW1_COLS01: row1_cols01 <= cfg_data;
        REG_ROW1_COLS23: row1_cols23 <= cfg_data;
        REG_ROW2_COLS01: row2_cols01 <= cfg_data;
        REG_ROW2_COLS23: row2_cols23 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the point
  assign in_x = s_axis_tdata[COORD_W-1:0];
  assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_z = s_axis_tdata[3*COORD_W-1:2*COORD_W];

  aff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  // One datapath per row; low word of cols01 is the first coefficient
  aff_row u_row0 (
    .clk   (clk),
    .ctrl  (ctrl),
    .m0    (row0_cols01[COORD_W-1:0]),
    .m1    (row0_cols01[CFG_W-1:COORD_W]),
    .m2    (row0_cols23[COORD_W-1:0]),
    .t     (row0_cols23[CFG_W-1:COORD_W]),
    .x     (in_x),
    .y     (in_y),
    .z     (in_z),
    .coord (out_x),
    .clamp (clamp_x)
  );

  aff_row u_row1 (
    .clk   (clk),
    .ctrl  (ctrl),
    .m0    (row1_cols01[COORD_W-1:0]),
    .m1    (row1_cols01[CFG_W-1:COORD_W]),
    .m2    (row1_cols23[COORD_W-1:0]),
    .t     (row1_cols23[CFG_W-1:COORD_W]),
    .x     (in_x),
    .y     (in_y),
    .z     (in_z),
    .coord (out_y),
    .clamp (clamp_y)
  );

  aff_row u_row2 (
    .clk   (clk),
    .ctrl  (ctrl),
    .m0    (row2_cols01[COORD_W-1:0]),
    .m1    (row2_cols01[CFG_W-1:COORD_W]),
    .m2    (row2_cols23[COORD_W-1:0]),
    .t     (row2_cols23[CFG_W-1:COORD_W]),
    .x     (in_x),
    .y     (in_y),
    .z     (in_z),
    .coord (out_z),
    .clamp (clamp_z)
  );

  // Pack the result; the flag merges the three row clamps
  assign m_axis_tdata = {out_z, out_y, out_x};
  assign m_axis_tuser = clamp_x || clamp_y || clamp_z;

  // The pipe must take a point whenever some stage is free
  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    (stat.valid != 3'b111) |-> s_axis_tready)
    else $error("input stalled while a pipeline stage was free");

  // An accepted point always lands in the multiply stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> stat.valid[0])
    else $error("accepted point did not enter the pipeline");

  // The clamp flag implies a coordinate sits at a saturation limit
  a_clamp_limit: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (out_x == COORD_MAX || out_x == COORD_MIN ||
       out_y == COORD_MAX || out_y == COORD_MIN ||
       out_z == COORD_MAX || out_z == COORD_MIN))
    else $error("clamp flagged without a saturated coordinate");

endmodule
